// File: design/msd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_pkg
// Shared widths, parser state codes and the result record of the deframer.
// ----------------------------------------------------------------------------
package msd_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 22;

	localparam logic [BYTE_W-1:0] HDR_CONT_BIT = 8'h80;
	localparam logic [BYTE_W-1:0] HDR_DEFL_BIT = 8'h40;
	localparam logic [BYTE_W-1:0] HDR_LOW7     = 8'h7f;
	localparam logic [BYTE_W-1:0] HDR_LOW6     = 8'h3f;

	typedef enum logic [3:0] {
		PH_HDR1 = 4'b0001,
		PH_HDR2 = 4'b0010,
		PH_HDR3 = 4'b0100,
		PH_BODY = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] payload_byte;
		logic              last_of_message;
		logic              empty_message;
		logic              huffman_coded;
		logic              deflate_coded;
		logic [LEN_W-1:0]  message_length;
	} result_t;

endpackage

// File: design/message_stream_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_stream_deframer_core
// Splits a byte stream into messages with 1 to 3 byte headers and forwards
// each payload byte with its coding flags, or one marker for an empty message.
//
//   channel  direction  handshake            payload
//   rx       in         rx_valid/rx_stall    rx_byte
//   res      out        res_valid/res_stall  payload_byte, last_of_message,
//                                            empty_message, huffman_coded,
//                                            deflate_coded, message_length
//
// one byte per cycle sustained while no result is held back by res_stall;
// a result passes the input register, then the result register
// header bytes that give no result pass the input register without waiting
// reset clears the parser to expect a first header byte, flags huffman
// res_stall backs up through the input register to rx_stall in the same cycle
// ----------------------------------------------------------------------------
module message_stream_deframer_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rx_valid,
	output logic                       rx_stall,
	input  logic [msd_pkg::BYTE_W-1:0] rx_byte,
	output logic                       res_valid,
	input  logic                       res_stall,
	output logic [msd_pkg::BYTE_W-1:0] payload_byte,
	output logic                       last_of_message,
	output logic                       empty_message,
	output logic                       huffman_coded,
	output logic                       deflate_coded,
	output logic [msd_pkg::LEN_W-1:0]  message_length
);
	import msd_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              has_res;
	logic              out_free;
	logic              adv;
	result_t           res_c;
	result_t           res_o;

	assign adv      = valid_s1 && (!has_res || out_free);
	assign rx_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	msd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx_byte (byte_s1),
		.fire    (adv),
		.has_res (has_res),
		.res     (res_c)
	);

	msd_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (adv && has_res),
		.res_in  (res_c),
		.stall   (res_stall),
		.valid   (res_valid),
		.free    (out_free),
		.res_out (res_o)
	);

	assign payload_byte    = res_o.payload_byte;
	assign last_of_message = res_o.last_of_message;
	assign empty_message   = res_o.empty_message;
	assign huffman_coded   = res_o.huffman_coded;
	assign deflate_coded   = res_o.deflate_coded;
	assign message_length  = res_o.message_length;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> valid_s1 && has_res && res_valid && res_stall)
		else $error("input stalled without a blocked result");

	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv && has_res |=> res_valid)
		else $error("result lost");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> huffman_coded != deflate_coded)
		else $error("coding flags inconsistent");

endmodule

// File: design/msd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_parser
// Header decode and payload countdown; builds the result for one stream byte
// and updates the message state when that byte moves on.
// ----------------------------------------------------------------------------
module msd_parser (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [msd_pkg::BYTE_W-1:0] rx_byte,
	input  logic                      fire,
	output logic                      has_res,
	output msd_pkg::result_t          res
);
	import msd_pkg::*;

	phase_t             phase_q, phase_d;
	logic [LEN_W-1:0]   length_q, length_d;
	logic [LEN_W-1:0]   left_q, left_d;
	logic               defl_q, defl_d;
	logic               huff_q, huff_d;
	logic               hdr_done;
	logic               body_last;

	assign body_last = (left_q <= LEN_W'(1));

	always_comb begin
		phase_d  = phase_q;
		length_d = length_q;
		left_d   = left_q;
		defl_d   = defl_q;
		huff_d   = huff_q;
		hdr_done = 1'b0;
		case (phase_q)
			PH_HDR1: begin
				length_d = LEN_W'(rx_byte & HDR_LOW7);
				defl_d   = 1'b0;
				huff_d   = 1'b1;
				if ((rx_byte & HDR_CONT_BIT) != '0) begin
					phase_d = PH_HDR2;
				end else begin
					hdr_done = 1'b1;
				end
			end
			PH_HDR2: begin
				if ((rx_byte & HDR_CONT_BIT) != '0) begin
					defl_d   = 1'b1;
					huff_d   = 1'b0;
					length_d = length_q | (LEN_W'(rx_byte & HDR_LOW7) << 7);
					phase_d  = PH_HDR3;
				end else begin
					if ((rx_byte & HDR_DEFL_BIT) != '0) begin
						defl_d = 1'b1;
						huff_d = 1'b0;
					end
					length_d = length_q | (LEN_W'(rx_byte & HDR_LOW6) << 7);
					hdr_done = 1'b1;
				end
			end
			PH_HDR3: begin
				length_d = length_q | (LEN_W'(rx_byte) << 14);
				hdr_done = 1'b1;
			end
			PH_BODY: begin
				if (body_last) begin
					left_d  = '0;
					phase_d = PH_HDR1;
				end else begin
					left_d = left_q - LEN_W'(1);
				end
			end
			default: begin
				phase_d = PH_HDR1;
			end
		endcase
		if (hdr_done) begin
			if (length_d == '0) begin
				left_d  = '0;
				phase_d = PH_HDR1;
			end else begin
				left_d  = length_d;
				phase_d = PH_BODY;
			end
		end
	end

	always_comb begin
		has_res             = 1'b0;
		res.payload_byte    = '0;
		res.last_of_message = 1'b1;
		res.empty_message   = 1'b1;
		res.huffman_coded   = huff_d;
		res.deflate_coded   = defl_d;
		res.message_length  = length_d;
		if (phase_q == PH_BODY) begin
			has_res             = 1'b1;
			res.payload_byte    = rx_byte;
			res.last_of_message = body_last;
			res.empty_message   = 1'b0;
		end else if (hdr_done && length_d == '0) begin
			has_res = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR1;
			length_q <= '0;
			left_q   <= '0;
			defl_q   <= 1'b0;
			huff_q   <= 1'b1;
		end else if (fire) begin
			phase_q  <= phase_d;
			length_q <= length_d;
			left_q   <= left_d;
			defl_q   <= defl_d;
			huff_q   <= huff_d;
		end
	end

	a_body_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> left_q != '0)
		else $error("payload phase with nothing left");

	a_left_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> left_q <= length_q)
		else $error("countdown above message length");

	a_empty_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fire && has_res && res.empty_message |=> phase_q == PH_HDR1)
		else $error("empty message did not restart header");

endmodule

// File: design/msd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module msd_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  msd_pkg::result_t res_in,
	input  logic             stall,
	output logic             valid,
	output logic             free,
	output msd_pkg::result_t res_out
);
	import msd_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign free    = !valid_q || !stall;
	assign valid   = valid_q;
	assign res_out = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && stall |-> !load)
		else $error("held item overwritten");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && res_q.empty_message |-> res_q.last_of_message && res_q.payload_byte == '0)
		else $error("empty marker malformed");

	a_empty_no_len: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && res_q.empty_message |-> res_q.message_length == '0)
		else $error("empty marker with length");

endmodule
